>>> src/tet_pkg.sv
// token expiry table package: word types, command and status codes,
// sequencer states and the control bundle shared by the modules
// no dependencies
package tet_pkg;

  // default geometry
  localparam int TABLE_ENTRIES_DEF = 64;
  localparam int KEY_BITS_DEF      = 32;

  // fixed field widths
  localparam int TOKEN_W = 32;
  localparam int TIME_W  = 32;
  localparam int TTL_W   = 31;
  localparam int EXP_W   = 33;
  localparam int COUNT_W = 7;

  // command codes
  localparam logic [1:0] CMD_GENERATE = 2'd0;
  localparam logic [1:0] CMD_RENEW    = 2'd1;
  localparam logic [1:0] CMD_COUNT    = 2'd2;

  // status codes
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_RENEW_IGN = 2'd1;
  localparam logic [1:0] STS_FULL      = 2'd2;

  // reset value of the lifetime register
  localparam logic [TTL_W-1:0] TTL_RESET = TTL_W'(1);

  typedef struct packed {
    logic [1:0]         cmd;
    logic [TOKEN_W-1:0] token_key;
    logic [TIME_W-1:0]  now_time;
  } tet_in_t;

  typedef struct packed {
    logic [COUNT_W-1:0] unexpired_count;
    logic [1:0]         status;
  } tet_out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_WRITE,
    ST_FINISH
  } tet_state_t;

  // sequencer strobes towards the datapath
  typedef struct packed {
    logic start;     // word accepted, capture and reset accumulators
    logic rd_en;     // table read issued this cycle
    logic beat;      // table read data valid this cycle
    logic clear_wr;  // clearing pass write
    logic commit;    // writeback cycle
    logic load;      // result loaded into output register
  } tet_ctl_t;

endpackage

>>> src/tet_table.sv
// token expiry table storage: one write port, one registered read port
// depends on nothing but its parameters
module tet_table #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 66
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/tet_scan.sv
// token expiry table scan unit: one key compare, one expiry compare and
// one counter, stepped once per entry read; forms the writeback decision
// depends on tet_pkg
module tet_scan #(
  parameter int TABLE_ENTRIES = tet_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = tet_pkg::KEY_BITS_DEF
) (
  input  logic                             clk,
  input  tet_pkg::tet_ctl_t                ctl,
  input  logic [1:0]                       cmd,
  input  logic [KEY_BITS-1:0]              key,
  input  logic [tet_pkg::TIME_W-1:0]       now_time,
  input  logic                             ent_valid,
  input  logic [KEY_BITS-1:0]              ent_key,
  input  logic [tet_pkg::EXP_W-1:0]        ent_expiry,
  output logic                             wr_ok,
  output logic [$clog2(TABLE_ENTRIES)-1:0] wr_idx,
  output tet_pkg::tet_out_t                result
);
  import tet_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  logic [IDX_W-1:0] idx_r;
  logic             match_found_r;
  logic             match_live_r;
  logic [IDX_W-1:0] match_idx_r;
  logic             free_found_r;
  logic [IDX_W-1:0] free_idx_r;
  logic [CNT_W-1:0] count_r;

  logic                 live;
  logic                 match;
  logic [CNT_W+6:0]     count_ext;

  // shared compare unit on the entry coming out of the table
  assign live  = ent_valid && (ent_expiry > {1'b0, now_time});
  assign match = ent_valid && (ent_key == key);

  // accumulate first match, first reusable slot and live count
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      idx_r         <= '0;
      match_found_r <= 1'b0;
      match_live_r  <= 1'b0;
      match_idx_r   <= '0;
      free_found_r  <= 1'b0;
      free_idx_r    <= '0;
      count_r       <= '0;
    end else if (ctl.beat) begin
      idx_r <= idx_r + IDX_W'(1);
      if (match && !match_found_r) begin
        match_found_r <= 1'b1;
        match_live_r  <= live;
        match_idx_r   <= idx_r;
      end
      if (!live && !free_found_r) begin
        free_found_r <= 1'b1;
        free_idx_r   <= idx_r;
      end
      if (live) begin
        count_r <= count_r + CNT_W'(1);
      end
    end
  end

  assign count_ext = {7'd0, count_r};

  // writeback decision
  always_comb begin
    wr_ok                  = 1'b0;
    wr_idx                 = match_idx_r;
    result.unexpired_count = '0;
    result.status          = STS_DONE;
    unique case (cmd)
      CMD_GENERATE: begin
        if (match_found_r) begin
          wr_ok = 1'b1;
        end else if (free_found_r) begin
          wr_ok  = 1'b1;
          wr_idx = free_idx_r;
        end else begin
          result.status = STS_FULL;
        end
      end
      CMD_RENEW: begin
        if (match_found_r && match_live_r) begin
          wr_ok = 1'b1;
        end else begin
          result.status = STS_RENEW_IGN;
        end
      end
      CMD_COUNT: begin
        result.unexpired_count = count_ext[COUNT_W-1:0];
      end
      default: begin
        result.status = STS_DONE;
      end
    endcase
  end

endmodule

>>> src/tet_ctrl.sv
// token expiry table sequencer: clearing pass, table sweep, writeback
// and hand-off to the output register
// depends on tet_pkg
module tet_ctrl #(
  parameter int TABLE_ENTRIES = tet_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             out_free,
  output logic                             in_stall,
  output logic [$clog2(TABLE_ENTRIES)-1:0] addr,
  output tet_pkg::tet_ctl_t                ctl
);
  import tet_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
  localparam logic [CNT_W-1:0] LAST = CNT_W'(TABLE_ENTRIES - 1);
  localparam logic [CNT_W-1:0] ENDS = CNT_W'(TABLE_ENTRIES);

  tet_state_t       state_r;
  tet_state_t       state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             beat_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR:  if (cnt_r == LAST) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:   if (cnt_r == ENDS) state_nxt = ST_WRITE;
      ST_WRITE:  state_nxt = ST_FINISH;
      ST_FINISH: if (out_free) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // entry counter
  always_comb begin
    cnt_nxt = cnt_r;
    unique case (state_r)
      ST_CLEAR: cnt_nxt = cnt_r + CNT_W'(1);
      ST_IDLE:  cnt_nxt = '0;
      ST_SCAN:  if (cnt_r != ENDS) cnt_nxt = cnt_r + CNT_W'(1);
      default:  cnt_nxt = cnt_r;
    endcase
  end

  // outputs
  always_comb begin
    in_stall     = (state_r != ST_IDLE);
    ctl.start    = (state_r == ST_IDLE) && in_valid;
    ctl.rd_en    = (state_r == ST_SCAN) && (cnt_r != ENDS);
    ctl.beat     = beat_r;
    ctl.clear_wr = (state_r == ST_CLEAR);
    ctl.commit   = (state_r == ST_WRITE);
    ctl.load     = (state_r == ST_FINISH) && out_free;
    addr         = cnt_r[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      cnt_r   <= '0;
      beat_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      beat_r  <= (state_r == ST_SCAN) && (cnt_r != ENDS);
    end
  end

endmodule

>>> src/token_expiry_table.sv
// token expiry table: from accepted word to result, a sweep of one table
// read per cycle, the last read's capture, writeback and output load (the
// load waits while the output register is held); one word at a time, the
// next taken only back in the idle state
// reset: synchronous, then a clearing pass that writes every table entry
// with in_stall high; lifetime register resets to 1
module token_expiry_table #(
  parameter int TABLE_ENTRIES = tet_pkg::TABLE_ENTRIES_DEF,
  parameter int KEY_BITS      = tet_pkg::KEY_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  tet_pkg::tet_in_t             in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output tet_pkg::tet_out_t            out_data,
  input  logic                         cfg_wr_en,
  input  logic [tet_pkg::TTL_W-1:0]    cfg_wr_data
);
  import tet_pkg::*;

  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int ENT_W = 1 + KEY_BITS + EXP_W;

  tet_ctl_t           ctl;
  logic [IDX_W-1:0]   addr;
  logic               out_free;
  logic [TTL_W-1:0]   ttl_r;
  logic [1:0]         cmd_r;
  logic [KEY_BITS-1:0] key_r;
  logic [TIME_W-1:0]  now_r;
  logic [EXP_W-1:0]   expiry_r;
  logic [KEY_BITS+TOKEN_W-1:0] key_ext;
  logic               out_valid_r;
  tet_out_t           out_data_r;
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr;
  logic [ENT_W-1:0]   mem_wdata;
  logic [ENT_W-1:0]   mem_rdata;
  logic               wr_ok;
  logic [IDX_W-1:0]   wr_idx;
  tet_out_t           result;

  // lifetime register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ttl_r <= TTL_RESET;
    end else if (cfg_wr_en) begin
      ttl_r <= cfg_wr_data;
    end
  end

  // capture the word and its new expiry
  assign key_ext = {{KEY_BITS{1'b0}}, in_data.token_key};

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      cmd_r    <= in_data.cmd;
      key_r    <= key_ext[KEY_BITS-1:0];
      now_r    <= in_data.now_time;
      expiry_r <= {1'b0, in_data.now_time} + {2'b00, ttl_r};
    end
  end

  tet_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .out_free (out_free),
    .in_stall (in_stall),
    .addr     (addr),
    .ctl      (ctl)
  );

  // write port: clearing pass or writeback
  always_comb begin
    mem_we    = ctl.clear_wr || (ctl.commit && wr_ok);
    mem_waddr = ctl.clear_wr ? addr : wr_idx;
    mem_wdata = ctl.clear_wr ? '0 : {1'b1, key_r, expiry_r};
  end

  tet_table #(
    .DEPTH (TABLE_ENTRIES),
    .WIDTH (ENT_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (ctl.rd_en),
    .raddr (addr),
    .rdata (mem_rdata)
  );

  tet_scan #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .KEY_BITS      (KEY_BITS)
  ) u_scan (
    .clk        (clk),
    .ctl        (ctl),
    .cmd        (cmd_r),
    .key        (key_r),
    .now_time   (now_r),
    .ent_valid  (mem_rdata[ENT_W-1]),
    .ent_key    (mem_rdata[ENT_W-2 -: KEY_BITS]),
    .ent_expiry (mem_rdata[EXP_W-1:0]),
    .wr_ok      (wr_ok),
    .wr_idx     (wr_idx),
    .result     (result)
  );

  // output register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // not ready straight after reset while the table is being cleared
  a_clear_after_reset: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(rst_n) |-> in_stall)
    else $error("word accepted during clearing pass");

  // an accepted word holds off the next one
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second word accepted while busy");

  // a count never writes the table
  a_count_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && cmd_r == CMD_COUNT) |-> !mem_we)
    else $error("table written on count");

  // a full table leaves the table untouched
  a_full_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && result.status == STS_FULL) |-> !mem_we)
    else $error("table written on full generate");
`endif

endmodule
